/* src/fxmm_pkg.sv */
// fxmm_pkg: shared types, codes and default sizes for the fixed-point matrix multiplier.
// No dependencies; imported by every module under src except fxmm_ram.
package fxmm_pkg;

    // Default sizes handed to the top-level parameters
    localparam int MAX_DIM_DEF    = 16;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int ACC_WIDTH_DEF  = 40;

    // Fixed port field widths
    localparam int CFG_W  = 5;
    localparam int CIDX_W = 2;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 16;
    localparam int KIND_W = 2;

    // Inner index width, wide enough for the largest supported dimension (64)
    localparam int K_W = 6;

    // Results per row are capped at this count
    localparam int OUT_LIMIT = 16;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COLS_B     = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [IDX_W-1:0]        result_row;
        logic [IDX_W-1:0]        result_col;
        logic                    row_last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic             acc_clr;
        logic             out_load;
        logic             out_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [K_W-1:0]   k;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

/* src/fxmm_ram.sv */
// fxmm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fxmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fxmm_datapath.sv */
// fxmm_datapath: A/B stores, multiply-accumulate pipeline, rounding and output register.
// Depends on fxmm_pkg and fxmm_ram.
module fxmm_datapath import fxmm_pkg::*; #(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic signed [VAL_W-1:0] i_wr_value,
    output t_dp_status              o_status,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 2 * DATA_WIDTH;
    localparam int EXT_W = (PW > ACC_WIDTH) ? PW : ACC_WIDTH;
    localparam logic [ACC_WIDTH-1:0] HALF = ACC_WIDTH'(1) << (FRAC_BITS - 1);

    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr_a;
    logic [AW-1:0]                 rd_addr_b;
    logic [DATA_WIDTH-1:0]         wr_data;
    logic [DATA_WIDTH-1:0]         a_q;
    logic [DATA_WIDTH-1:0]         b_q;
    logic signed [PW-1:0]          prod;
    logic signed [EXT_W-1:0]       prod_ext;
    logic [ACC_WIDTH-1:0]          rnd;
    logic signed [ACC_WIDTH-1:0]   shifted;
    logic [DATA_WIDTH-1:0]         res;

    logic                          r_v1;
    logic                          r_v2;
    logic signed [PW-1:0]          r_prod;
    logic [ACC_WIDTH-1:0]          r_acc;
    logic                          r_out_valid;
    t_out_item                     r_out_data;

    // Row-major addressing: entry (r, c) lives at r * MAX_DIM + c
    assign wr_addr   = AW'(int'(i_cmd.row) * MAX_DIM + int'(i_cmd.col));
    assign rd_addr_a = AW'(int'(i_cmd.row) * MAX_DIM + int'(i_cmd.k));
    assign rd_addr_b = AW'(int'(i_cmd.k) * MAX_DIM + int'(i_cmd.col));
    assign wr_data   = DATA_WIDTH'(i_wr_value);

    fxmm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_a),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr_a),
        .o_rdata (a_q)
    );

    fxmm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_b),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr_b),
        .o_rdata (b_q)
    );

    assign prod     = $signed(a_q) * $signed(b_q);
    assign prod_ext = EXT_W'(r_prod);

    // Round half up, arithmetic shift, wrap to the data width
    assign rnd     = r_acc + HALF;
    assign shifted = $signed(rnd) >>> FRAC_BITS;
    assign res     = DATA_WIDTH'(shifted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= prod;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + prod_ext[ACC_WIDTH-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_data.result_value <= VAL_W'(res);
            r_out_data.result_row   <= i_cmd.row;
            r_out_data.result_col   <= i_cmd.col;
            r_out_data.row_last     <= i_cmd.out_last;
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

endmodule

/* src/fxmm_ctrl.sv */
// fxmm_ctrl: configuration registers and the sequencer over result columns and inner index.
// Depends on fxmm_pkg.
module fxmm_ctrl import fxmm_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output t_dp_cmd           o_cmd,
    input  t_dp_status        i_status
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int EW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int NLIM  = (MAX_DIM < OUT_LIMIT) ? MAX_DIM : OUT_LIMIT;
    localparam logic [EW-1:0] CAP   = EW'(MAX_DIM);
    localparam logic [EW-1:0] NCAP  = EW'(NLIM);
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CFG_W-1:0] r_rows_a, r_inner_size, r_cols_b;
    logic [EW-1:0]    r_kn, n_kn;
    logic [EW-1:0]    r_n, n_n;
    logic [EW-1:0]    r_k, n_k;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_row, n_row;

    logic             in_acc;
    logic [EW-1:0]    m_eff, kn_eff, n_eff;
    logic [EW-1:0]    row_ext, col_ext;
    logic             in_range;
    logic             col_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;

    // Registers above the store size act as the store size
    assign m_eff  = (EW'(r_rows_a) > CAP) ? CAP : EW'(r_rows_a);
    assign kn_eff = (EW'(r_inner_size) > CAP) ? CAP : EW'(r_inner_size);
    assign n_eff  = (EW'(r_cols_b) > NCAP) ? NCAP : EW'(r_cols_b);

    assign row_ext  = EW'(i_in_data.row);
    assign col_ext  = EW'(i_in_data.col);
    assign in_range = (row_ext < CAP) && (col_ext < CAP);
    assign col_last = (EW'(r_j) == r_n - EW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a     <= CFG_RESET;
            r_inner_size <= CFG_RESET;
            r_cols_b     <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS_A:     r_rows_a     <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_COLS_B:     r_cols_b     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_kn    = r_kn;
        n_n     = r_n;
        n_k     = r_k;
        n_j     = r_j;
        n_row   = r_row;
        o_cmd   = '0;
        o_cmd.row = r_row;
        o_cmd.col = r_j;
        o_cmd.k   = K_W'(r_k);

        case (r_state)
            S_IDLE: begin
                o_cmd.row = i_in_data.row;
                o_cmd.col = i_in_data.col;
                if (in_acc) begin
                    case (i_in_data.kind)
                        KIND_LOAD_A: o_cmd.wr_a = in_range;
                        KIND_LOAD_B: o_cmd.wr_b = in_range;
                        KIND_COMPUTE: begin
                            if ((row_ext < m_eff) && (n_eff != '0)) begin
                                o_cmd.acc_clr = 1'b1;
                                n_row = i_in_data.row;
                                n_kn  = kn_eff;
                                n_n   = n_eff;
                                n_k   = '0;
                                n_j   = '0;
                                n_state = (kn_eff == '0) ? S_DRAIN : S_ISSUE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                if (r_k == r_kn - EW'(1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + EW'(1);
                end
            end
            S_DRAIN: begin
                // Sum complete once the MAC pipe is empty; hand off when the output slot frees
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = col_last;
                    o_cmd.acc_clr  = 1'b1;
                    if (col_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j = r_j + IDX_W'(1);
                        n_k = '0;
                        n_state = (r_kn == '0) ? S_DRAIN : S_ISSUE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kn  <= n_kn;
        r_n   <= n_n;
        r_k   <= n_k;
        r_j   <= n_j;
        r_row <= n_row;
    end

endmodule

/* src/fixed_point_matrix_multiply.sv */
// fixed_point_matrix_multiply: top level of the Q-format matrix multiplier C = A x B.
// Depends on fxmm_pkg, fxmm_ctrl, fxmm_datapath (which holds two fxmm_ram stores).
//
// Usage
//   Config channel (i_cfg_*): writes rows_a (index 0), inner_size (1), cols_b (2); always
//   ready, one transfer per cycle. Write only while the block is idle.
//   Input channel (i_in_*): one item per transfer. Load A / load B items write one element
//   each and are taken whenever the block is idle, so loads stream back to back. A compute
//   item for row i makes the block emit C[i][0..cols_b-1] on the output channel, row_last
//   set on the final one. Each result takes one store read per inner step (none when
//   inner_size is zero), then the read, multiply and accumulate stages drain; during a
//   full row o_in_ready is low. The inner loop over the single read port of each store
//   sets the time per result.
//   Output channel (o_out_*): a single output register. A stall holds the result and
//   pauses the sequencer before the next element is loaded; no data is lost.
//   Reset: synchronous, active low; all three registers return to 16, the sequencer to
//   idle and the output empty. Store contents are undefined until written.
module fixed_point_matrix_multiply import fxmm_pkg::*; #(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // input items
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer: config registers, load decode, column / inner-index loops
    fxmm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // Stores, MAC pipe, rounding and output register
    fxmm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_wr_value  (i_in_data.value),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/sv/fixed_point_matrix_multiply_checker.sv */
// fixed_point_matrix_multiply_checker: watches the config, input and result channels of the
// fixed-point matrix multiplier, predicts every result element and compares it field by field.
// Depends on fxmm_pkg for the payload structs, item kinds and register indexes.
module fixed_point_matrix_multiply_checker
    import fxmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_item         i_out_data,
    output int                o_fail_count,
    output int                o_due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM   = MAX_DIM_DEF;
    localparam int ACC_W = ACC_WIDTH_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC - 1);

    logic signed [VAL_W-1:0] a_store [DIM][DIM];
    logic signed [VAL_W-1:0] b_store [DIM][DIM];
    logic [CFG_W-1:0]        rows_reg  = CFG_W'(DIM);
    logic [CFG_W-1:0]        inner_reg = CFG_W'(DIM);
    logic [CFG_W-1:0]        cols_reg  = CFG_W'(DIM);
    t_out_item               row_elems_due [$];
    t_out_item               want;
    int                      fails = 0;

    function automatic int clamp_dim(logic [CFG_W-1:0] v);
        return (v > DIM) ? DIM : int'(v);
    endfunction

    // sum of products in the wide accumulator, round half up, arithmetic shift, wrap
    function automatic logic [VAL_W-1:0] dot_product(int r, int c, int depth);
        logic signed [ACC_W-1:0]   acc;
        logic signed [2*VAL_W-1:0] prod;
        acc = '0;
        for (int k = 0; k < depth; k++) begin
            prod = a_store[r][k] * b_store[k][c];
            acc  = acc + prod;
        end
        acc = acc + HALF_LSB;
        acc = acc >>> FRAC;
        return acc[VAL_W-1:0];
    endfunction

    function automatic void queue_row(logic [IDX_W-1:0] r);
        int        m;
        int        depth;
        int        n;
        t_out_item e;
        m     = clamp_dim(rows_reg);
        depth = clamp_dim(inner_reg);
        n     = clamp_dim(cols_reg);
        if (n > OUT_LIMIT)
            n = OUT_LIMIT;
        if (int'(r) >= m)
            return;
        for (int j = 0; j < n; j++) begin
            e.result_value = dot_product(int'(r), j, depth);
            e.result_row   = r;
            e.result_col   = IDX_W'(j);
            e.row_last     = (j == n - 1);
            row_elems_due.push_back(e);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg  = CFG_W'(DIM);
            inner_reg = CFG_W'(DIM);
            cols_reg  = CFG_W'(DIM);
            row_elems_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (row_elems_due.size() == 0) begin
                    $error("unexpected result: row %0d col %0d value %0d",
                           i_out_data.result_row, i_out_data.result_col,
                           i_out_data.result_value);
                    fails++;
                end else begin
                    want = row_elems_due.pop_front();
                    if (i_out_data.result_value !== want.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, i_out_data.result_value);
                        fails++;
                    end
                    if (i_out_data.result_row !== want.result_row) begin
                        $error("result_row: expected %0d, got %0d",
                               want.result_row, i_out_data.result_row);
                        fails++;
                    end
                    if (i_out_data.result_col !== want.result_col) begin
                        $error("result_col: expected %0d, got %0d",
                               want.result_col, i_out_data.result_col);
                        fails++;
                    end
                    if (i_out_data.row_last !== want.row_last) begin
                        $error("row_last: expected %0d, got %0d",
                               want.row_last, i_out_data.row_last);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROWS_A:     rows_reg  = i_cfg_data;
                    CFG_INNER_SIZE: inner_reg = i_cfg_data;
                    CFG_COLS_B:     cols_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.kind)
                    KIND_LOAD_A:  a_store[i_in_data.row][i_in_data.col] = i_in_data.value;
                    KIND_LOAD_B:  b_store[i_in_data.row][i_in_data.col] = i_in_data.value;
                    KIND_COMPUTE: queue_row(i_in_data.row);
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_due_count  <= row_elems_due.size();
    end

endmodule

/* tb/sv/fixed_point_matrix_multiply_tb.sv */
// fixed_point_matrix_multiply_tb: clock, reset, stimulus and verdict for the matrix multiplier.
// Depends on fxmm_pkg, the RTL under src and fixed_point_matrix_multiply_checker.
module fixed_point_matrix_multiply_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fxmm_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEM_TARGET = 450;
    // wait long enough for the worst row at full size, plus margin
    localparam int SETTLE_CYCLES = MAX_DIM_DEF * (MAX_DIM_DEF + 3) + 16;
    // kind 3 has no meaning; the block must drop it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in_item          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b1;
    t_out_item         out_data;
    int                fail_count;
    int                due_count;

    // stretches without idling on either side
    bit steady_send = 1'b0;
    bit steady_recv = 1'b0;
    int recv_hold   = 0;
    int cycle_cnt   = 0;
    int items_sent  = 0;

    // effective sizes as the block should see them, for picking legal indexes
    int dim_rows  = MAX_DIM_DEF;
    int dim_inner = MAX_DIM_DEF;
    int dim_cols  = MAX_DIM_DEF;

    // which store entries hold a written value; reads of others are never caused
    bit a_set [MAX_DIM_DEF][MAX_DIM_DEF];
    bit b_set [MAX_DIM_DEF][MAX_DIM_DEF];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    fixed_point_matrix_multiply i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    fixed_point_matrix_multiply_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    // hard stop if the block hangs
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("fixed_point_matrix_multiply_tb: FAIL");
            $finish;
        end
    end

    // mostly short gaps, some long; a gap of zero keeps the stream moving
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // register value for a phase: small sizes dominate, zero and oversize now and then
    function automatic int draw_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (r < 65)
            return $urandom_range(1, 4);
        if (r < 85)
            return $urandom_range(5, 15);
        if (r < 93)
            return MAX_DIM_DEF;
        return $urandom_range(MAX_DIM_DEF + 1, 31);
    endfunction

    function automatic int span(int d);
        return (d == 0) ? 1 : d;
    endfunction

    // result side: ready drops for a drawn number of cycles between bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b1;
            recv_hold <= 0;
        end else if (recv_hold != 0) begin
            out_ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else if (steady_recv) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= 1'b1;
            recv_hold <= draw_gap();
        end
    end

    // one transfer on the input channel; valid stays high if the next item follows at once
    task automatic push_item(input t_in_item it);
        int gap;
        gap = steady_send ? 0 : draw_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (it.kind == KIND_LOAD_A)
            a_set[it.row][it.col] = 1'b1;
        if (it.kind == KIND_LOAD_B)
            b_set[it.row][it.col] = 1'b1;
        if (it.kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic load_elem(input logic [KIND_W-1:0] kind, input int r, input int c,
                             input logic [VAL_W-1:0] v);
        t_in_item it;
        it.kind  = kind;
        it.row   = IDX_W'(r);
        it.col   = IDX_W'(c);
        it.value = v;
        push_item(it);
    endtask

    // loads whatever the row still lacks, then asks for the row; col and value are noise
    task automatic compute_row(input int r);
        t_in_item it;
        if (r < dim_rows && dim_cols != 0) begin
            for (int k = 0; k < dim_inner; k++)
                if (!a_set[r][k])
                    load_elem(KIND_LOAD_A, r, k, VAL_W'($urandom));
            for (int k = 0; k < dim_inner; k++)
                for (int j = 0; j < dim_cols; j++)
                    if (!b_set[k][j])
                        load_elem(KIND_LOAD_B, k, j, VAL_W'($urandom));
        end
        it.kind  = KIND_COMPUTE;
        it.row   = IDX_W'(r);
        it.col   = IDX_W'($urandom);
        it.value = VAL_W'($urandom);
        push_item(it);
    endtask

    task automatic send_unused();
        t_in_item it;
        it.kind  = KIND_UNUSED;
        it.row   = IDX_W'($urandom);
        it.col   = IDX_W'($urandom);
        it.value = VAL_W'($urandom);
        push_item(it);
    endtask

    // sender holds off until every predicted element has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // registers change only once the block is idle; rows with no output may still be running
    task automatic set_dims(input int r, input int k, input int c);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_ROWS_A, r);
        write_reg(CFG_INNER_SIZE, k);
        write_reg(CFG_COLS_B, c);
        cfg_valid <= 1'b0;
        dim_rows  = (r > MAX_DIM_DEF) ? MAX_DIM_DEF : r;
        dim_inner = (k > MAX_DIM_DEF) ? MAX_DIM_DEF : k;
        dim_cols  = (c > MAX_DIM_DEF) ? MAX_DIM_DEF : c;
        if (dim_cols > OUT_LIMIT)
            dim_cols = OUT_LIMIT;
    endtask

    initial begin
        int base;
        int pick;
        int n_items;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: 2x2 product with extreme values and rounding edges
        set_dims(2, 2, 2);
        load_elem(KIND_LOAD_A, 0, 0, 16'h7FFF);
        load_elem(KIND_LOAD_A, 0, 1, 16'h8000);
        load_elem(KIND_LOAD_A, 1, 0, 16'h0001);
        load_elem(KIND_LOAD_A, 1, 1, 16'hFFFF);
        load_elem(KIND_LOAD_B, 0, 0, 16'h7FFF);
        load_elem(KIND_LOAD_B, 0, 1, 16'h0080);   // exactly half an LSB against A = 1
        load_elem(KIND_LOAD_B, 1, 0, 16'h8000);
        load_elem(KIND_LOAD_B, 1, 1, 16'hFF7F);
        compute_row(0);                            // wraps far past 16 bits
        compute_row(1);
        compute_row(2);                            // row beyond rows_a: nothing back
        send_unused();
        // top corner of both stores, alternating bit patterns
        load_elem(KIND_LOAD_A, 15, 15, 16'h5555);
        load_elem(KIND_LOAD_B, 15, 15, 16'hAAAA);
        // zero-sized configurations
        set_dims(0, 2, 2);
        compute_row(0);                            // no rows at all
        set_dims(2, 2, 0);
        compute_row(1);                            // no columns: no results
        set_dims(2, 0, 2);
        compute_row(1);                            // empty sum rounds to zero

        // --- random phases; the first two pin the upper extremes incl. oversize values
        base = items_sent;
        for (int phase = 0; items_sent - base < ITEM_TARGET; phase++) begin
            if (phase == 0)
                set_dims(31, MAX_DIM_DEF, 3);
            else if (phase == 1)
                set_dims(MAX_DIM_DEF, 3, 31);
            else
                set_dims(draw_dim(), draw_dim(), draw_dim());
            steady_send = ($urandom_range(0, 3) == 0);
            steady_recv <= ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(20, 50);
            repeat (n_items) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    // overwrite entries inside the active matrices
                    if ($urandom_range(0, 1) == 0)
                        load_elem(KIND_LOAD_A, $urandom_range(0, span(dim_rows) - 1),
                                  $urandom_range(0, span(dim_inner) - 1), VAL_W'($urandom));
                    else
                        load_elem(KIND_LOAD_B, $urandom_range(0, span(dim_inner) - 1),
                                  $urandom_range(0, span(dim_cols) - 1), VAL_W'($urandom));
                end else if (pick < 45) begin
                    load_elem($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A,
                              $urandom_range(0, 15), $urandom_range(0, 15), VAL_W'($urandom));
                end else if (pick < 85) begin
                    compute_row($urandom_range(0, span(dim_rows) - 1));
                end else if (pick < 91) begin
                    compute_row($urandom_range(0, 15));   // often out of range
                end else if (pick < 96) begin
                    send_unused();
                end else begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && due_count == 0)
            $display("fixed_point_matrix_multiply_tb: PASS");
        else
            $display("fixed_point_matrix_multiply_tb: FAIL");
        $finish;
    end

endmodule
